>>> src/dpf_pkg.sv
// Shared types and constants for the delta pack with fallback block.
// Used by every module under src; depends on nothing else.
`timescale 1ns / 1ps

package dpf_pkg;

  // Fixed field widths
  localparam int SAMPLE_W = 32;
  localparam int HALF_W   = 16;
  localparam int WCNT_W   = 7;

  // Default block depth
  localparam int MAX_SAMPLES_DEF = 64;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ISSUE,
    ST_PROC
  } state_e;

  // Result of the shared difference unit
  typedef struct packed {
    logic [HALF_W-1:0] lo;
    logic              in_range;
  } diff_res_t;

endpackage

>>> src/delta_pack_with_fallback_core.sv
// Top level of the delta pack with fallback block.
// Instantiates dpf_sample_mem, dpf_diff_unit and dpf_ctrl; uses dpf_pkg.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------------
//   in      | input     | in_valid_i / in_stall_o | sample_i, last_i
//   out     | output    | out_valid_o/out_stall_i | word_o, raw_mode_o, total_words_o,
//           |           |                         | last_word_o
//
// Each input sample is written through the buffer's write port.
// After the closing sample, each buffered sample takes a buffer read
// (ST_ISSUE) and a pass through the shared difference unit (ST_PROC),
// plus any output stall; a packed word goes out on every second sample,
// a raw word on every sample.
// Reset clears the sequencer, fill level and output valid; the buffer needs
// no clearing. No input transaction is accepted while a block is emitted.
`timescale 1ns / 1ps

module delta_pack_with_fallback_core
  import dpf_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic                last_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [SAMPLE_W-1:0] word_o,
  output logic                raw_mode_o,
  output logic [WCNT_W-1:0]   total_words_o,
  output logic                last_word_o
);

  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);

  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [SAMPLE_W-1:0] mem_wdata;
  logic                mem_re;
  logic [AW-1:0]       mem_raddr;
  logic [SAMPLE_W-1:0] mem_rdata;
  logic [SAMPLE_W-1:0] opa;
  logic [SAMPLE_W-1:0] opb;
  diff_res_t           diff_res;

  // Sample buffer
  dpf_sample_mem #(
    .DEPTH (MAX_SAMPLES),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Shared difference unit
  dpf_diff_unit u_diff (
    .opa_i (opa),
    .opb_i (opb),
    .res_o (diff_res)
  );

  // Sequencer and output register
  dpf_ctrl #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .AW          (AW),
    .CW          (CW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_i      (sample_i),
    .last_i        (last_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .word_o        (word_o),
    .raw_mode_o    (raw_mode_o),
    .total_words_o (total_words_o),
    .last_word_o   (last_word_o),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_re_o      (mem_re),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata),
    .opa_o         (opa),
    .opb_o         (opb),
    .diff_i        (diff_res)
  );

endmodule

>>> src/dpf_sample_mem.sv
// Sample buffer: one write port, one read port with registered read data.
// Depends on dpf_pkg for the sample width.
`timescale 1ns / 1ps

module dpf_sample_mem
  import dpf_pkg::*;
#(
  parameter int DEPTH = MAX_SAMPLES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  logic [SAMPLE_W-1:0] wdata_i,
  input  logic                re_i,
  input  logic [AW-1:0]       raddr_i,
  output logic [SAMPLE_W-1:0] rdata_o
);

  logic [SAMPLE_W-1:0] mem_q [DEPTH];
  logic [SAMPLE_W-1:0] rdata_q;

  // Write the incoming sample
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read and hold until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/dpf_diff_unit.sv
// Shared difference unit: exact 33-bit difference of two signed samples,
// its low half and a 16-bit range check. Depends on dpf_pkg.
`timescale 1ns / 1ps

module dpf_diff_unit
  import dpf_pkg::*;
(
  input  logic signed [SAMPLE_W-1:0] opa_i,
  input  logic signed [SAMPLE_W-1:0] opb_i,
  output diff_res_t                  res_o
);

  logic signed [SAMPLE_W:0] diff;

  // Subtract at one extra bit so the result never wraps
  assign diff = {opa_i[SAMPLE_W-1], opa_i} - {opb_i[SAMPLE_W-1], opb_i};

  // In range when all bits above the half's sign bit match it
  assign res_o.in_range = (&diff[SAMPLE_W:HALF_W-1]) | ~(|diff[SAMPLE_W:HALF_W-1]);
  assign res_o.lo       = diff[HALF_W-1:0];

endmodule

>>> src/dpf_ctrl.sv
// Sequencer for loading a block and emitting packed or raw words.
// Drives the sample buffer and the shared difference unit; uses dpf_pkg.
`timescale 1ns / 1ps

module dpf_ctrl
  import dpf_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
  parameter int AW          = $clog2(MAX_SAMPLES),
  parameter int CW          = $clog2(MAX_SAMPLES + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic                last_i,
  // output channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [SAMPLE_W-1:0] word_o,
  output logic                raw_mode_o,
  output logic [WCNT_W-1:0]   total_words_o,
  output logic                last_word_o,
  // sample buffer
  output logic                mem_we_o,
  output logic [AW-1:0]       mem_waddr_o,
  output logic [SAMPLE_W-1:0] mem_wdata_o,
  output logic                mem_re_o,
  output logic [AW-1:0]       mem_raddr_o,
  input  logic [SAMPLE_W-1:0] mem_rdata_i,
  // difference unit
  output logic [SAMPLE_W-1:0] opa_o,
  output logic [SAMPLE_W-1:0] opb_o,
  input  diff_res_t           diff_i
);

  state_e state_q, state_d;

  logic [CW-1:0]       fill_q;
  logic                range_q;
  logic [CW-1:0]       n_q;
  logic                raw_q;
  logic [CW-1:0]       j_q;
  logic [SAMPLE_W-1:0] prev_q;
  logic [HALF_W-1:0]   lo_q;

  logic                out_valid_q;
  logic [SAMPLE_W-1:0] out_word_q;
  logic                out_raw_q;
  logic [WCNT_W-1:0]   out_cnt_q;
  logic                out_last_q;

  logic                in_acc;
  logic                blk_end;
  logic                range_d;
  logic                out_free;
  logic                j_last;
  logic                emit_need;
  logic                adv;
  logic                out_load;
  logic [SAMPLE_W-1:0] word_d;
  logic [WCNT_W-1:0]   cnt_d;

  // Decode handshake and block boundaries
  assign in_acc    = in_valid_i & ~in_stall_o;
  assign blk_end   = last_i | (fill_q == CW'(MAX_SAMPLES - 1));
  assign range_d   = range_q | ((fill_q != '0) & ~diff_i.in_range);
  assign out_free  = ~out_valid_q | ~out_stall_i;
  assign j_last    = (j_q == n_q - CW'(1));
  assign emit_need = raw_q | (j_q == '0) | ~j_q[0] | j_last;
  assign adv       = (state_q == ST_PROC) & (~emit_need | out_free);
  assign out_load  = adv & emit_need;

  // Select the emitted word
  always_comb begin
    if (raw_q || (j_q == '0)) begin
      word_d = mem_rdata_i;
    end else if (j_q[0]) begin
      word_d = {{HALF_W{1'b0}}, diff_i.lo};
    end else begin
      word_d = {diff_i.lo, lo_q};
    end
    if (raw_q) begin
      cnt_d = WCNT_W'(n_q);
    end else begin
      cnt_d = WCNT_W'(n_q >> 1) + WCNT_W'(1);
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_acc && blk_end) state_d = ST_ISSUE;
      end
      ST_ISSUE: begin
        state_d = ST_PROC;
      end
      ST_PROC: begin
        if (adv) state_d = j_last ? ST_LOAD : ST_ISSUE;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall_o  = 1'b1;
    mem_re_o    = 1'b0;
    opa_o       = mem_rdata_i;
    unique case (state_q)
      ST_LOAD: begin
        in_stall_o = 1'b0;
        opa_o      = sample_i;
      end
      ST_ISSUE: begin
        mem_re_o = 1'b1;
      end
      ST_PROC: begin
        opa_o = mem_rdata_i;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  assign opb_o       = prev_q;
  assign mem_we_o    = in_acc;
  assign mem_waddr_o = fill_q[AW-1:0];
  assign mem_wdata_o = sample_i;
  assign mem_raddr_o = j_q[AW-1:0];

  // Advance the state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // Track fill level, range flag and emission index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      range_q <= 1'b0;
      n_q     <= '0;
      raw_q   <= 1'b0;
      j_q     <= '0;
    end else if (in_acc) begin
      if (blk_end) begin
        fill_q  <= '0;
        range_q <= 1'b0;
        n_q     <= fill_q + CW'(1);
        raw_q   <= range_d;
        j_q     <= '0;
      end else begin
        fill_q  <= fill_q + CW'(1);
        range_q <= range_d;
      end
    end else if (adv) begin
      j_q <= j_q + CW'(1);
    end
  end

  // Hold the previous sample and the pending low half
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      prev_q <= sample_i;
    end else if (adv) begin
      prev_q <= mem_rdata_i;
      if (j_q[0]) lo_q <= diff_i.lo;
    end
  end

  // Output register: drop on acceptance, load when free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_word_q <= word_d;
      out_raw_q  <= raw_q;
      out_cnt_q  <= cnt_d;
      out_last_q <= j_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign word_o        = out_word_q;
  assign raw_mode_o    = out_raw_q;
  assign total_words_o = out_cnt_q;
  assign last_word_o   = out_last_q;

  // Fill level never reaches the depth while loading
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < CW'(MAX_SAMPLES))
    else $error("fill level out of range");

  // Emission index stays inside the block
  a_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_LOAD) |-> ((n_q != '0) && (j_q < n_q)))
    else $error("emission index beyond block");

  // Final word returns the sequencer to loading
  a_last_to_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && j_last) |=> (state_q == ST_LOAD))
    else $error("block did not close after final word");

  // Output word only loads when the register is free
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !out_load)
    else $error("output register overwritten while stalled");

endmodule
